FILE: sv/r235fs_pkg.sv
// package for the radix 2-3-5 factor split block
// holds widths, datapath op codes, jump conditions and the microprogram rom
// no dependencies
`default_nettype none

package r235fs_pkg;

	// width of the size operand
	localparam int SIZE_BITS = 31;

	// result field widths
	localparam int W_EXP_TWO = 5;
	localparam int W_EXP_THREE = 5;
	localparam int W_EXP_FIVE = 4;
	localparam int W_SPLIT_X = 16;
	localparam int W_SPLIT_Y = 31;

	// internal widths
	localparam int EXP_W = $clog2(SIZE_BITS);
	localparam int CNT_W = $clog2(SIZE_BITS + 1);
	localparam int ROOT_W = (SIZE_BITS + 1) / 2;
	localparam int SQ_W = 2 * ROOT_W;
	localparam int UPC_W = 5;

	// inverses of 3 and 5 modulo 2^SIZE_BITS, and the largest quotient of each
	localparam logic [SIZE_BITS-1:0] INV_THREE = SIZE_BITS'(64'hAAAA_AAAA_AAAA_AAAB);
	localparam logic [SIZE_BITS-1:0] INV_FIVE = SIZE_BITS'(64'hCCCC_CCCC_CCCC_CCCD);
	localparam logic [SIZE_BITS-1:0] QMAX_THREE =
		SIZE_BITS'(((64'd1 << SIZE_BITS) - 64'd1) / 64'd3);
	localparam logic [SIZE_BITS-1:0] QMAX_FIVE =
		SIZE_BITS'(((64'd1 << SIZE_BITS) - 64'd1) / 64'd5);

	typedef enum logic [4:0] {
		OP_NOP,
		OP_HALVE,
		OP_DIV_MUL3,
		OP_DIV_MUL5,
		OP_DIV_END3,
		OP_DIV_END5,
		OP_SQ_INIT,
		OP_SQ_MUL,
		OP_SQ_CMP,
		OP_SRCH_INIT,
		OP_CHECK,
		OP_NEXT_I,
		OP_NEXT_J,
		OP_NEXT_K,
		OP_CNT2,
		OP_CNT3,
		OP_CNT5,
		OP_MUL2,
		OP_MUL3,
		OP_MUL5,
		OP_DONE
	} dp_op_t;

	typedef enum logic [3:0] {
		JC_NEVER,
		JC_ALWAYS,
		JC_NOT_EVEN,
		JC_Q_LE1,
		JC_DIVIDES,
		JC_TB_MORE,
		JC_I_END,
		JC_J_END,
		JC_K_END,
		JC_CNT_ZERO
	} jc_t;

	typedef struct packed {
		dp_op_t op;
		jc_t jc;
		logic [UPC_W-1:0] target;
	} ucw_t;

	// program labels
	localparam logic [UPC_W-1:0] L_TWO = UPC_W'(0);
	localparam logic [UPC_W-1:0] L_THREE = UPC_W'(2);
	localparam logic [UPC_W-1:0] L_FIVE = UPC_W'(4);
	localparam logic [UPC_W-1:0] L_SQRT = UPC_W'(6);
	localparam logic [UPC_W-1:0] L_SQ = UPC_W'(7);
	localparam logic [UPC_W-1:0] L_CHK = UPC_W'(10);
	localparam logic [UPC_W-1:0] L_NEXTJ = UPC_W'(12);
	localparam logic [UPC_W-1:0] L_NEXTK = UPC_W'(14);
	localparam logic [UPC_W-1:0] L_NY = UPC_W'(16);
	localparam logic [UPC_W-1:0] L_Y2 = UPC_W'(17);
	localparam logic [UPC_W-1:0] L_Y3 = UPC_W'(19);
	localparam logic [UPC_W-1:0] L_Y3L = UPC_W'(20);
	localparam logic [UPC_W-1:0] L_Y5 = UPC_W'(22);
	localparam logic [UPC_W-1:0] L_Y5L = UPC_W'(23);
	localparam logic [UPC_W-1:0] L_OUT = UPC_W'(25);

	// microprogram: one control word per step
	function automatic ucw_t urom(input logic [UPC_W-1:0] addr);
		ucw_t w;
		unique case (addr)
			UPC_W'(0):  w = '{OP_NOP,       JC_NOT_EVEN, L_THREE};
			UPC_W'(1):  w = '{OP_HALVE,     JC_ALWAYS,   L_TWO};
			UPC_W'(2):  w = '{OP_DIV_MUL3,  JC_Q_LE1,    L_FIVE};
			UPC_W'(3):  w = '{OP_DIV_END3,  JC_DIVIDES,  L_THREE};
			UPC_W'(4):  w = '{OP_DIV_MUL5,  JC_Q_LE1,    L_SQRT};
			UPC_W'(5):  w = '{OP_DIV_END5,  JC_DIVIDES,  L_FIVE};
			UPC_W'(6):  w = '{OP_SQ_INIT,   JC_NEVER,    L_TWO};
			UPC_W'(7):  w = '{OP_SQ_MUL,    JC_NEVER,    L_TWO};
			UPC_W'(8):  w = '{OP_SQ_CMP,    JC_TB_MORE,  L_SQ};
			UPC_W'(9):  w = '{OP_SRCH_INIT, JC_NEVER,    L_TWO};
			UPC_W'(10): w = '{OP_CHECK,     JC_I_END,    L_NEXTJ};
			UPC_W'(11): w = '{OP_NEXT_I,    JC_ALWAYS,   L_CHK};
			UPC_W'(12): w = '{OP_NOP,       JC_J_END,    L_NEXTK};
			UPC_W'(13): w = '{OP_NEXT_J,    JC_ALWAYS,   L_CHK};
			UPC_W'(14): w = '{OP_NOP,       JC_K_END,    L_NY};
			UPC_W'(15): w = '{OP_NEXT_K,    JC_ALWAYS,   L_CHK};
			UPC_W'(16): w = '{OP_CNT2,      JC_NEVER,    L_TWO};
			UPC_W'(17): w = '{OP_NOP,       JC_CNT_ZERO, L_Y3};
			UPC_W'(18): w = '{OP_MUL2,      JC_ALWAYS,   L_Y2};
			UPC_W'(19): w = '{OP_CNT3,      JC_NEVER,    L_TWO};
			UPC_W'(20): w = '{OP_NOP,       JC_CNT_ZERO, L_Y5};
			UPC_W'(21): w = '{OP_MUL3,      JC_ALWAYS,   L_Y3L};
			UPC_W'(22): w = '{OP_CNT5,      JC_NEVER,    L_TWO};
			UPC_W'(23): w = '{OP_NOP,       JC_CNT_ZERO, L_OUT};
			UPC_W'(24): w = '{OP_MUL5,      JC_ALWAYS,   L_Y5L};
			UPC_W'(25): w = '{OP_DONE,      JC_NEVER,    L_TWO};
			default:    w = '{OP_DONE,      JC_NEVER,    L_TWO};
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

FILE: sv/radix_235_factor_split.sv
// top level of the radix 2-3-5 factor split block: microcoded sequencer and datapath
// depends on r235fs_pkg (widths, op codes, microprogram rom)
`default_nettype none

// Takes a transform size and returns the exponents of 2, 3 and 5 in it, plus a
// split split_x * split_y of its 2-3-5 part, split_x being the 2-3-5 product,
// with exponents at most half those of the size rounded up, nearest to, but
// not above, the integer square root of the size. An item is taken when start
// is high and busy is low; busy stays high until the result, which done flags
// by going high for exactly one cycle. The receiver cannot stall, so it must
// take the result in that cycle. One item is worked on at a time: the
// sequencer runs one control word per cycle. The run length is data
// dependent: the program halves out each factor of 2, makes trial divisions
// by 3 and 5 (one more trial than the exponent for each, skipped once the
// quotient reaches 1), finds the square root with a square and a compare per
// root bit, checks each split candidate in turn and multiplies split_y up one
// factor at a time. A trial division is one multiply by the inverse of the
// divisor modulo 2^SIZE_BITS followed by a compare; the candidate search
// dominates for sizes rich in 2, 3 and 5.

module radix_235_factor_split
	import r235fs_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	output logic                        busy,
	input  wire logic [SIZE_BITS-1:0]   size_in,
	output logic                        done,
	output logic [W_EXP_TWO-1:0]        exp_two,
	output logic [W_EXP_THREE-1:0]      exp_three,
	output logic [W_EXP_FIVE-1:0]       exp_five,
	output logic [W_SPLIT_X-1:0]        split_x,
	output logic [W_SPLIT_Y-1:0]        split_y
);

	// sequencer
	logic             busy_q;
	logic             done_q;
	logic [UPC_W-1:0] upc_q;
	ucw_t             uw;
	logic             jump_take;

	// factoring
	logic [SIZE_BITS-1:0] n_q;
	logic [SIZE_BITS-1:0] q_q;
	logic [EXP_W-1:0]     e2_q;
	logic [EXP_W-1:0]     e3_q;
	logic [EXP_W-1:0]     e5_q;

	// trial division by 3 or 5 through the modular inverse
	logic [SIZE_BITS-1:0] dq_q;
	logic                 div_hit;

	// square root, one root bit per square step and compare step
	logic [ROOT_W-1:0] root_q;
	logic [ROOT_W-1:0] tb_q;
	logic [SQ_W-1:0]   sq_q;
	logic [ROOT_W-1:0] trial;

	// candidate search
	logic [SIZE_BITS-1:0] cand_q;
	logic [SIZE_BITS-1:0] pjk_q;
	logic [SIZE_BITS-1:0] pk_q;
	logic [ROOT_W-1:0]    best_q;
	logic [ROOT_W-1:0]    bx_q;
	logic [EXP_W-1:0]     i_q;
	logic [EXP_W-1:0]     j_q;
	logic [EXP_W-1:0]     k_q;
	logic [EXP_W-1:0]     bi_q;
	logic [EXP_W-1:0]     bj_q;
	logic [EXP_W-1:0]     bk_q;
	logic [EXP_W:0]       sum2;
	logic [EXP_W:0]       sum3;
	logic [EXP_W:0]       sum5;
	logic                 cand_fits;
	logic [ROOT_W-1:0]    cand_diff;
	logic                 better;
	logic [SIZE_BITS-1:0] pjk_x3;
	logic [SIZE_BITS-1:0] pk_x5;

	// split_y accumulator and its factor count
	logic [SIZE_BITS-1:0] y_q;
	logic [CNT_W-1:0]     cnt_q;

	logic q_gt1;

	assign uw = urom(upc_q);

	assign q_gt1 = |q_q[SIZE_BITS-1:1];

	// q times the inverse is the exact quotient when the divisor divides q,
	// and lands above the largest possible quotient otherwise
	assign div_hit = (uw.op == OP_DIV_END5) ? (dq_q <= QMAX_FIVE) : (dq_q <= QMAX_THREE);

	assign trial = root_q | tb_q;

	// exponent limits (e + 1) / 2
	assign sum2 = {1'b0, e2_q} + 1'b1;
	assign sum3 = {1'b0, e3_q} + 1'b1;
	assign sum5 = {1'b0, e5_q} + 1'b1;

	// strictly smaller residual wins, so ties keep the earlier candidate
	assign cand_fits = SIZE_BITS'(root_q) >= cand_q;
	assign cand_diff = root_q - cand_q[ROOT_W-1:0];
	assign better = cand_fits && (cand_diff < best_q);

	assign pjk_x3 = pjk_q + (pjk_q << 1);
	assign pk_x5 = pk_q + (pk_q << 2);

	// jump condition of the current control word, on present register values
	always_comb begin
		unique case (uw.jc)
			JC_NEVER:    jump_take = 1'b0;
			JC_ALWAYS:   jump_take = 1'b1;
			JC_NOT_EVEN: jump_take = !(q_gt1 && !q_q[0]);
			JC_Q_LE1:    jump_take = !q_gt1;
			JC_DIVIDES:  jump_take = div_hit;
			JC_TB_MORE:  jump_take = !tb_q[0];
			JC_I_END:    jump_take = i_q == sum2[EXP_W:1];
			JC_J_END:    jump_take = j_q == sum3[EXP_W:1];
			JC_K_END:    jump_take = k_q == sum5[EXP_W:1];
			JC_CNT_ZERO: jump_take = cnt_q == '0;
			default:     jump_take = 1'b0;
		endcase
	end

	// step counter and handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			upc_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (!busy_q) begin
				if (start) begin
					busy_q <= 1'b1;
					upc_q <= L_TWO;
				end
			end else begin
				if (uw.op == OP_DONE) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				upc_q <= jump_take ? uw.target : upc_q + 1'b1;
			end
		end
	end

	// datapath, driven by the op field of the control word
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			n_q <= size_in;
			q_q <= size_in;
			e2_q <= '0;
			e3_q <= '0;
			e5_q <= '0;
		end else if (busy_q) begin
			unique case (uw.op)
				OP_NOP: ;
				OP_HALVE: begin
					q_q <= q_q >> 1;
					e2_q <= e2_q + 1'b1;
				end
				OP_DIV_MUL3: dq_q <= q_q * INV_THREE;
				OP_DIV_MUL5: dq_q <= q_q * INV_FIVE;
				OP_DIV_END3: begin
					if (div_hit) begin
						q_q <= dq_q;
						e3_q <= e3_q + 1'b1;
					end
				end
				OP_DIV_END5: begin
					if (div_hit) begin
						q_q <= dq_q;
						e5_q <= e5_q + 1'b1;
					end
				end
				OP_SQ_INIT: begin
					root_q <= '0;
					tb_q <= {1'b1, {(ROOT_W-1){1'b0}}};
				end
				OP_SQ_MUL: begin
					sq_q <= SQ_W'(trial) * SQ_W'(trial);
				end
				OP_SQ_CMP: begin
					if (sq_q <= SQ_W'(n_q)) begin
						root_q <= trial;
					end
					tb_q <= tb_q >> 1;
				end
				OP_SRCH_INIT: begin
					best_q <= root_q;
					bx_q <= ROOT_W'(1);
					bi_q <= '0;
					bj_q <= '0;
					bk_q <= '0;
					i_q <= '0;
					j_q <= '0;
					k_q <= '0;
					cand_q <= SIZE_BITS'(1);
					pjk_q <= SIZE_BITS'(1);
					pk_q <= SIZE_BITS'(1);
				end
				OP_CHECK: begin
					if (better) begin
						best_q <= cand_diff;
						bx_q <= cand_q[ROOT_W-1:0];
						bi_q <= i_q;
						bj_q <= j_q;
						bk_q <= k_q;
					end
				end
				OP_NEXT_I: begin
					i_q <= i_q + 1'b1;
					cand_q <= cand_q << 1;
				end
				OP_NEXT_J: begin
					j_q <= j_q + 1'b1;
					i_q <= '0;
					pjk_q <= pjk_x3;
					cand_q <= pjk_x3;
				end
				OP_NEXT_K: begin
					k_q <= k_q + 1'b1;
					j_q <= '0;
					i_q <= '0;
					pk_q <= pk_x5;
					pjk_q <= pk_x5;
					cand_q <= pk_x5;
				end
				OP_CNT2: begin
					y_q <= SIZE_BITS'(1);
					cnt_q <= CNT_W'(e2_q - bi_q);
				end
				OP_CNT3: cnt_q <= CNT_W'(e3_q - bj_q);
				OP_CNT5: cnt_q <= CNT_W'(e5_q - bk_q);
				OP_MUL2: begin
					y_q <= y_q << 1;
					cnt_q <= cnt_q - 1'b1;
				end
				OP_MUL3: begin
					y_q <= y_q + (y_q << 1);
					cnt_q <= cnt_q - 1'b1;
				end
				OP_MUL5: begin
					y_q <= y_q + (y_q << 2);
					cnt_q <= cnt_q - 1'b1;
				end
				OP_DONE: ;
				default: ;
			endcase
		end
	end

	// results hold from the done step until the next item is taken
	assign busy = busy_q;
	assign done = done_q;
	assign exp_two = W_EXP_TWO'(e2_q);
	assign exp_three = W_EXP_THREE'(e3_q);
	assign exp_five = W_EXP_FIVE'(e5_q);
	assign split_x = W_SPLIT_X'(bx_q);
	assign split_y = W_SPLIT_Y'(y_q);

	// an accepted item restarts the program at its first step
	a_start_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy_q) |=> (busy_q && upc_q == L_TWO))
		else $error("accepted item did not restart the sequencer");

	// the strobe comes only as the sequencer releases busy
	a_done_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (!busy_q && $past(busy_q)))
		else $error("result strobe without end of work");

	// an exact quotient is always below the dividend it came from
	a_div_quotient: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && (uw.op == OP_DIV_END3 || uw.op == OP_DIV_END5) && div_hit)
		|-> (dq_q < q_q))
		else $error("trial division quotient out of range");

	// the chosen factor never exceeds the square root
	a_split_x_le_root: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (bx_q <= root_q || root_q == '0))
		else $error("split_x above the square root");

	// the square root bound holds when the result leaves
	a_root_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (SQ_W'(root_q) * SQ_W'(root_q) <= SQ_W'(n_q)))
		else $error("square root too large");

endmodule

`default_nettype wire
